[rtl/core/krl_pkg.sv]
// ----------------------------------------------------------------------------
// krl_pkg
// types and constants shared by the keyed record list
// ----------------------------------------------------------------------------
package krl_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned NameBytes = 20;
  localparam int unsigned SlotW     = $clog2(Capacity);
  localparam int unsigned CountW    = $clog2(Capacity + 1);
  localparam int unsigned RecW      = 32 + 64 + 64 + 24 + 24 + 32;

  typedef enum logic [1:0] {
    KindInsert = 2'd0,
    KindRemove = 2'd1,
    KindGet    = 2'd2,
    KindSize   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        key;
    logic [63:0]        name_lo;
    logic [63:0]        name_mid;
    logic [23:0]        name_hi;
    logic [7:0]         name_length;
    logic signed [23:0] average;
    logic signed [31:0] absences;
    logic signed [15:0] position;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [31:0]        found_key;
    logic [63:0]        found_name_lo;
    logic [63:0]        found_name_mid;
    logic [23:0]        found_name_hi;
    logic signed [23:0] found_average;
    logic signed [31:0] found_absences;
    logic [6:0]         entry_total;
  } rsp_t;

  function automatic logic [63:0] byte_mask(logic [7:0] len, logic [7:0] base);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if ({24'd0, len} > {24'd0, base} + b) begin
        m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

[rtl/core/krl_ram.sv]
// ----------------------------------------------------------------------------
// krl_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module krl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[rtl/core/keyed_record_list.sv]
// ----------------------------------------------------------------------------
// keyed_record_list
// bounded singly linked list of records held in slot memories
// ----------------------------------------------------------------------------
// One beat is taken when start_i is high and busy_o is low; its result shows
// for one cycle under done_o, in the same cycle that busy_o falls, and cannot
// be stalled. Size answers without reading memory, insert takes the head of
// the free list as the new list head, a get walks the list to position p, and
// remove walks it one slot at a time until the key matches or the list ends.
// After reset a pass over all Capacity slots loads the link memory before the
// first beat is taken.
module keyed_record_list (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  krl_pkg::req_t   req_i,
  output logic            busy_o,
  output logic            done_o,
  output krl_pkg::rsp_t   rsp_o
);

  localparam int unsigned SW = krl_pkg::SlotW;
  localparam int unsigned CW = krl_pkg::CountW;
  localparam int unsigned RW = krl_pkg::RecW;

  typedef enum logic [2:0] {
    StInit, StIdle, StRead, StWait, StCheck, StLink, StDone
  } state_e;

  state_e          state_q;
  krl_pkg::req_t   req_q;
  logic [SW-1:0]   head_q, free_q, cur_q, prev_q, init_q;
  logic [CW-1:0]   count_q, idx_q;
  logic            first_q, hit_q;
  krl_pkg::rsp_t   rsp_q;
  logic            done_q;

  logic            lk_we, rc_we;
  logic [SW-1:0]   lk_addr, lk_wdata, lk_rdata, rc_addr;
  logic [RW-1:0]   rc_wdata, rc_rdata;

  krl_ram #(.Width(SW), .Depth(krl_pkg::Capacity)) u_link (
    .clk_i, .we_i(lk_we), .addr_i(lk_addr), .wdata_i(lk_wdata), .rdata_o(lk_rdata)
  );
  krl_ram #(.Width(RW), .Depth(krl_pkg::Capacity)) u_rec (
    .clk_i, .we_i(rc_we), .addr_i(rc_addr), .wdata_i(rc_wdata), .rdata_o(rc_rdata)
  );

  logic        ins_bad;
  logic [31:0] rd_key;
  assign rd_key  = rc_rdata[RW-1 -: 32];
  assign ins_bad = (req_q.name_length > 8'(krl_pkg::NameBytes - 1)) || req_q.average[23] ||
                   req_q.absences[31] || (count_q == CW'(krl_pkg::Capacity));

  // memory ports
  always_comb begin
    lk_we    = 1'b0;
    lk_addr  = cur_q;
    lk_wdata = '0;
    rc_we    = 1'b0;
    rc_addr  = cur_q;
    rc_wdata = {req_q.key,
                req_q.name_lo & krl_pkg::byte_mask(req_q.name_length, 8'd0),
                req_q.name_mid & krl_pkg::byte_mask(req_q.name_length, 8'd8),
                req_q.name_hi & 24'(krl_pkg::byte_mask(req_q.name_length, 8'd16)),
                req_q.average, req_q.absences};
    case (state_q)
      StInit: begin
        lk_we    = 1'b1;
        lk_addr  = init_q;
        lk_wdata = init_q + SW'(1);
      end
      StLink: begin
        lk_we = 1'b1;
        case (req_q.kind)
          krl_pkg::KindInsert: begin
            lk_addr  = free_q;
            lk_wdata = head_q;
            rc_we    = 1'b1;
            rc_addr  = free_q;
          end
          default: begin
            if (first_q) begin
              lk_addr  = cur_q;
              lk_wdata = free_q;
            end else begin
              lk_addr  = prev_q;
              lk_wdata = lk_rdata;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      req_q   <= '0;
      rsp_q   <= '0;
      head_q  <= '0;
      free_q  <= '0;
      count_q <= '0;
      init_q  <= '0;
      done_q  <= 1'b0;
      cur_q   <= '0;
      prev_q  <= '0;
      idx_q   <= '0;
      first_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StInit: begin
          init_q <= init_q + SW'(1);
          if (init_q == SW'(krl_pkg::Capacity - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (start_i) begin
            req_q   <= req_i;
            cur_q   <= head_q;
            idx_q   <= '0;
            first_q <= 1'b1;
            hit_q   <= 1'b0;
            rsp_q   <= '0;
            state_q <= StRead;
          end
        end
        StRead: begin
          case (req_q.kind)
            krl_pkg::KindInsert: begin
              cur_q   <= free_q;
              state_q <= ins_bad ? StDone : StWait;
            end
            krl_pkg::KindRemove: state_q <= (idx_q == count_q) ? StDone : StWait;
            krl_pkg::KindGet: begin
              if (req_q.position[15] ||
                  ({1'b0, req_q.position} >= {{(17-CW){1'b0}}, count_q}))
                state_q <= StDone;
              else state_q <= StWait;
            end
            default: begin
              rsp_q.ok <= 1'b1;
              state_q  <= StDone;
            end
          endcase
        end
        StWait: state_q <= StCheck;
        StCheck: begin
          case (req_q.kind)
            krl_pkg::KindInsert: state_q <= StLink;
            krl_pkg::KindRemove: begin
              if (rd_key == req_q.key) begin
                hit_q <= 1'b1;
                if (first_q) begin
                  head_q <= lk_rdata;
                  state_q <= StLink;
                end else begin
                  state_q <= StLink;
                end
              end else begin
                prev_q  <= cur_q;
                cur_q   <= lk_rdata;
                first_q <= 1'b0;
                idx_q   <= idx_q + CW'(1);
                state_q <= StRead;
              end
            end
            default: begin
              if ({{(16-CW){1'b0}}, idx_q} == req_q.position[15:0]) begin
                rsp_q.ok             <= 1'b1;
                {rsp_q.found_key, rsp_q.found_name_lo, rsp_q.found_name_mid,
                 rsp_q.found_name_hi, rsp_q.found_average,
                 rsp_q.found_absences} <= rc_rdata;
                state_q <= StDone;
              end else begin
                cur_q   <= lk_rdata;
                idx_q   <= idx_q + CW'(1);
                state_q <= StWait;
              end
            end
          endcase
        end
        StLink: begin
          // remove: unlink from prev first, then push cur on free list
          if (req_q.kind == krl_pkg::KindInsert) begin
            free_q   <= lk_rdata;
            head_q   <= free_q;
            count_q  <= count_q + CW'(1);
            rsp_q.ok <= 1'b1;
            state_q  <= StDone;
          end else if (!first_q && hit_q) begin
            // lk_rdata holds next of cur; write prev link now, then free
            state_q <= StLink;
            first_q <= 1'b1;
          end else begin
            free_q   <= cur_q;
            count_q  <= count_q - CW'(1);
            rsp_q.ok <= 1'b1;
            state_q  <= StDone;
          end
        end
        StDone: begin
          rsp_q.entry_total <= 7'(count_q);
          done_q  <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(krl_pkg::Capacity)) else $error("count overflow");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == StIdle) else $error("done outside idle");
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLink && req_q.kind == krl_pkg::KindInsert)
    |=> count_q == $past(count_q) + CW'(1))
    else $error("insert count");
`endif

endmodule
